### design/pid_regulator_assert.svh
// ---------------------------------------------------------------------------
// pid_regulator assertion macros
// Concurrent checks on clk, disabled while arst_n is low. Empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef PID_REGULATOR_ASSERT_SVH
`define PID_REGULATOR_ASSERT_SVH

`ifndef SYNTHESIS
// Check cons in the same cycle as ante.
`define PIDR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pid_regulator: same-cycle check failed");
// Check cons in the cycle after ante.
`define PIDR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pid_regulator: next-cycle check failed");
`else
`define PIDR_ASSERT_NOW(label, ante, cons)
`define PIDR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### design/pidr_pkg.sv
// ---------------------------------------------------------------------------
// pidr_pkg
// Widths, codes and clamp helpers shared by the PID regulator files.
// ---------------------------------------------------------------------------
package pidr_pkg;

	localparam int DATA_WIDTH      = 16;
	localparam int GAIN_FRAC_BITS  = 8;
	localparam int GAIN_WIDTH      = 16;
	localparam int CFG_INDEX_WIDTH = 3;
	localparam int CFG_DATA_WIDTH  = 16;

	localparam int INTEG_WIDTH = DATA_WIDTH + GAIN_FRAC_BITS;
	localparam int DIFF_WIDTH  = DATA_WIDTH + 1;
	localparam int SGAIN_WIDTH = GAIN_WIDTH + 1;
	localparam int PROD_WIDTH  = DIFF_WIDTH + SGAIN_WIDTH;
	localparam int SUM_WIDTH   = PROD_WIDTH + 2;

	typedef logic signed [DATA_WIDTH-1:0]  data_t;
	typedef logic        [GAIN_WIDTH-1:0]  gain_t;
	typedef logic signed [SGAIN_WIDTH-1:0] sgain_t;
	typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
	typedef logic signed [PROD_WIDTH-1:0]  prod_t;
	typedef logic signed [INTEG_WIDTH-1:0] integ_t;
	typedef logic signed [SUM_WIDTH-1:0]   sum_t;

	localparam data_t OUT_MAX_RESET = data_t'(255);

	typedef enum logic {
		OP_COMPUTE = 1'b0,
		OP_CLEAR   = 1'b1
	} op_t;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		CFG_PROP_GAIN    = 3'd0,
		CFG_INTEG_GAIN   = 3'd1,
		CFG_DERIV_GAIN   = 3'd2,
		CFG_OUT_MIN      = 3'd3,
		CFG_OUT_MAX      = 3'd4,
		CFG_REVERSE      = 3'd5,
		CFG_PROP_ON_MEAS = 3'd6
	} cfg_index_t;

	// Scale an integer limit into the fractional sum domain.
	function automatic sum_t limit_to_sum(data_t lim);
		return sum_t'(lim) <<< GAIN_FRAC_BITS;
	endfunction

	// Test the upper limit first, then the lower one.
	function automatic sum_t clamp_sum(sum_t v, sum_t lo, sum_t hi);
		if (v > hi)
			return hi;
		else if (v < lo)
			return lo;
		else
			return v;
	endfunction

	// Apply the direction to an unsigned gain.
	function automatic sgain_t signed_gain(gain_t g, logic reverse);
		sgain_t s;
		s = sgain_t'({1'b0, g});
		return reverse ? -s : s;
	endfunction

endpackage

### design/pidr_sample_if.sv
// ---------------------------------------------------------------------------
// pidr_sample_if
// Sample channel: one measurement/setpoint item per transfer.
// ---------------------------------------------------------------------------
interface pidr_sample_if;
	import pidr_pkg::*;

	logic  valid;
	logic  ready;
	op_t   operation;
	data_t measurement;
	data_t setpoint;
	logic  auto_enable;

	modport source (output valid, operation, measurement, setpoint, auto_enable, input ready);
	modport sink   (input valid, operation, measurement, setpoint, auto_enable, output ready);
endinterface

### design/pidr_result_if.sv
// ---------------------------------------------------------------------------
// pidr_result_if
// Result channel: controller drive and integral value per transfer.
// ---------------------------------------------------------------------------
interface pidr_result_if;
	import pidr_pkg::*;

	logic  valid;
	logic  ready;
	data_t drive;
	data_t integral_whole;

	modport source (output valid, drive, integral_whole, input ready);
	modport sink   (input valid, drive, integral_whole, output ready);
endinterface

### design/pid_regulator.sv
// ---------------------------------------------------------------------------
// pid_regulator
// Fixed-point PID controller with derivative on measurement, bumpless
// manual-to-auto transfer and clamped Q.8 integral.
// ---------------------------------------------------------------------------
//
//   channel   dir   handshake        payload
//   -------   ---   --------------   -----------------------------------------
//   sample    in    valid / ready    operation, measurement, setpoint, auto_enable
//   result    out   valid / ready    drive, integral_whole
//   cfg       in    cfg_we           cfg_index, cfg_data (write only)
//
// Each sample moves from the input register through the multipliers, adders
// and clamps into the result register. A new sample is taken every cycle
// while the result side does not stall; the integral and held output update
// on the step that loads the result register, which sets the rate at one per cycle.
// Reset zeroes integral, history, valid flags and config (out_max to 255); mode is auto.
// A stalled result blocks the input register only once both stages are full.
// ---------------------------------------------------------------------------
`include "pid_regulator_assert.svh"

module pid_regulator (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [pidr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [pidr_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
	pidr_sample_if.sink                          sample,
	pidr_result_if.source                        result
);
	import pidr_pkg::*;

	// Configuration registers
	gain_t prop_gain_q;
	gain_t integ_gain_q;
	gain_t deriv_gain_q;
	data_t out_min_q;
	data_t out_max_q;
	logic  reverse_q;
	logic  prop_on_meas_q;

	// Controller state
	integ_t integral_q;
	data_t  last_meas_q;
	data_t  held_q;
	logic   was_auto_q;

	// Input stage
	logic  valid_s1;
	op_t   operation_s1;
	data_t measurement_s1;
	data_t setpoint_s1;
	logic  auto_s1;

	// Result register
	logic  res_valid_q;
	data_t drive_q;
	data_t whole_q;

	logic advance;
	logic step;

	sum_t   lo_sum, hi_sum;
	sgain_t kp, ki, kd;
	diff_t  err, dmeas;
	prod_t  kp_err, kp_dmeas, ki_err, kd_dmeas;
	sum_t   integ_start, integ_acc, integ_clamped;
	sum_t   total, total_clamped;

	integ_t integral_next;
	data_t  held_next;
	data_t  last_meas_next;
	logic   was_auto_next;

	// Handshake: the input stage moves on whenever the result register is
	// empty or its content is being transferred out this cycle.
	assign advance      = !res_valid_q || result.ready;
	assign step         = valid_s1 && advance;
	assign sample.ready = !valid_s1 || advance;

	assign result.valid          = res_valid_q;
	assign result.drive          = drive_q;
	assign result.integral_whole = whole_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q    <= '0;
			integ_gain_q   <= '0;
			deriv_gain_q   <= '0;
			out_min_q      <= '0;
			out_max_q      <= OUT_MAX_RESET;
			reverse_q      <= 1'b0;
			prop_on_meas_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PROP_GAIN:    prop_gain_q    <= gain_t'(cfg_data);
				CFG_INTEG_GAIN:   integ_gain_q   <= gain_t'(cfg_data);
				CFG_DERIV_GAIN:   deriv_gain_q   <= gain_t'(cfg_data);
				CFG_OUT_MIN:      out_min_q      <= data_t'(cfg_data);
				CFG_OUT_MAX:      out_max_q      <= data_t'(cfg_data);
				CFG_REVERSE:      reverse_q      <= cfg_data[0];
				CFG_PROP_ON_MEAS: prop_on_meas_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Input register: load on every transfer, drop the valid once consumed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			operation_s1   <= sample.operation;
			measurement_s1 <= sample.measurement;
			setpoint_s1    <= sample.setpoint;
			auto_s1        <= sample.auto_enable;
		end
	end

	// Datapath. Limits and gains move into the Q.8 sum domain; the four
	// products run side by side and feed the integral and drive adders.
	always_comb begin
		lo_sum = limit_to_sum(out_min_q);
		hi_sum = limit_to_sum(out_max_q);

		kp = signed_gain(prop_gain_q, reverse_q);
		ki = signed_gain(integ_gain_q, reverse_q);
		kd = signed_gain(deriv_gain_q, reverse_q);

		err   = diff_t'(setpoint_s1) - diff_t'(measurement_s1);
		dmeas = diff_t'(measurement_s1) - diff_t'(last_meas_q);

		kp_err   = prod_t'(kp) * prod_t'(err);
		kp_dmeas = prod_t'(kp) * prod_t'(dmeas);
		ki_err   = prod_t'(ki) * prod_t'(err);
		kd_dmeas = prod_t'(kd) * prod_t'(dmeas);

		// Coming back from manual: seed the integral with the held output so
		// the drive picks up where the operator left it.
		if (was_auto_q)
			integ_start = sum_t'(integral_q);
		else
			integ_start = clamp_sum(limit_to_sum(held_q), lo_sum, hi_sum);

		integ_acc = integ_start + sum_t'(ki_err);
		if (prop_on_meas_q)
			integ_acc = integ_acc - sum_t'(kp_dmeas);
		integ_clamped = clamp_sum(integ_acc, lo_sum, hi_sum);

		total = integ_clamped - sum_t'(kd_dmeas);
		if (!prop_on_meas_q)
			total = total + sum_t'(kp_err);
		total_clamped = clamp_sum(total, lo_sum, hi_sum);
	end

	// Next state. Clamped sums always lie within the scaled 16-bit limits,
	// so the integral fits its register and the floor is a plain bit slice.
	always_comb begin
		integral_next  = integral_q;
		held_next      = held_q;
		last_meas_next = last_meas_q;
		was_auto_next  = was_auto_q;
		case (operation_s1)
			OP_CLEAR: begin
				integral_next = '0;
			end
			OP_COMPUTE: begin
				was_auto_next = auto_s1;
				if (auto_s1) begin
					integral_next  = integ_clamped[INTEG_WIDTH-1:0];
					held_next      = total_clamped[GAIN_FRAC_BITS +: DATA_WIDTH];
					last_meas_next = measurement_s1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q  <= '0;
			last_meas_q <= '0;
			held_q      <= '0;
			was_auto_q  <= 1'b1;
		end else if (step) begin
			integral_q  <= integral_next;
			last_meas_q <= last_meas_next;
			held_q      <= held_next;
			was_auto_q  <= was_auto_next;
		end
	end

	// Result register: refill on each step, hold while the sink stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			drive_q <= held_next;
			whole_q <= integral_next[INTEG_WIDTH-1:GAIN_FRAC_BITS];
		end
	end

	`PIDR_ASSERT_NEXT(a_manual_keeps_integral,
		step && operation_s1 == OP_COMPUTE && !auto_s1, $stable(integral_q))
	`PIDR_ASSERT_NEXT(a_clear_zeroes_integral,
		step && operation_s1 == OP_CLEAR, integral_q == '0)
	`PIDR_ASSERT_NEXT(a_held_only_in_auto,
		step && (operation_s1 == OP_CLEAR || !auto_s1), $stable(held_q))
	`PIDR_ASSERT_NOW(a_result_from_stage, $rose(res_valid_q), $past(valid_s1))
	`PIDR_ASSERT_NOW(a_drive_tracks_held, res_valid_q, drive_q == held_q)

endmodule

### bench/pid_regulator_tb.sv
// ---------------------------------------------------------------------------
// pid_regulator_tb
// Self-checking bench for the PID regulator. A cycle-free predictor tracks
// integral, held drive, last measurement and mode for every sample transfer
// and queues the drive and integral it implies; each result transfer is
// checked against the oldest entry. Directed samples hit the field extremes,
// manual mode, bumpless return, integral clear, reverse action, proportional
// on measurement and inverted limits. Random phases then reprogram the loop
// and run tracking sequences under random idling; a last test adds one long result stall.
// ---------------------------------------------------------------------------
module pid_regulator_tb;
	import pidr_pkg::*;

	localparam int PHASES         = 20;
	localparam int PHASE_ITEMS    = 50;
	localparam int PRESSURE_ITEMS = 30;
	localparam int HOLD_OFF_LEN   = 80;
	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	// Index beyond the register map; a write there must change nothing.
	localparam logic [CFG_INDEX_WIDTH-1:0] NO_SUCH_REG = '1;

	typedef struct packed {
		data_t drive;
		data_t integral_whole;
	} outcome_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index;
	logic [CFG_DATA_WIDTH-1:0]  cfg_data;

	pidr_sample_if sample_ch ();
	pidr_result_if result_ch ();

	pid_regulator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample_ch),
		.result    (result_ch)
	);

	// Bench copy of the register file.
	gain_t kp_cfg, ki_cfg, kd_cfg;
	data_t min_cfg, max_cfg;
	logic  reverse_cfg, pom_cfg;

	// Bench copy of the loop state; the sum is Q.8 and always fits 40 bits.
	longint integ_acc;
	data_t  prev_meas;
	data_t  drive_hold;
	logic   auto_prev;

	outcome_t pending_outcomes[$];
	int       mismatches;
	int       results_seen;
	bit       stream_fast;      // no idling on either side while set
	int       hold_off_cycles;  // one long result stall, taken by the sink
	int       manual_left;
	data_t    walk_meas, walk_sp;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// -----------------------------------------------------------------------
	// Predictor
	// -----------------------------------------------------------------------
	function automatic longint clamp_to(longint v, longint lo, longint hi);
		// When the limits cross, the upper limit is tested first.
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	function automatic longint directed_gain(gain_t g);
		return reverse_cfg ? -longint'(g) : longint'(g);
	endfunction

	// Advance the loop state by one sample and queue the result it yields.
	task automatic regulate(op_t op, data_t meas, data_t sp, logic auto_on);
		longint   scale, lo, hi, err, dmeas, kp, ki, kd, total, whole, smax;
		outcome_t outcome;
		scale = longint'(1) << GAIN_FRAC_BITS;
		lo    = longint'(min_cfg) * scale;
		hi    = longint'(max_cfg) * scale;
		smax  = (longint'(1) << (DATA_WIDTH - 1)) - 1;
		if (op == OP_CLEAR) begin
			// Clear touches only the integral; mode and history stay.
			integ_acc = 0;
		end else begin
			// Bumpless return: seed the integral from the held drive.
			if (auto_on && !auto_prev)
				integ_acc = clamp_to(longint'(drive_hold) * scale, lo, hi);
			auto_prev = auto_on;
			if (auto_on) begin
				err   = longint'(sp) - longint'(meas);
				dmeas = longint'(meas) - longint'(prev_meas);
				kp    = directed_gain(kp_cfg);
				ki    = directed_gain(ki_cfg);
				kd    = directed_gain(kd_cfg);
				integ_acc = integ_acc + ki * err;
				if (pom_cfg)
					integ_acc = integ_acc - kp * dmeas;
				integ_acc = clamp_to(integ_acc, lo, hi);
				total = pom_cfg ? 0 : kp * err;
				total = clamp_to(total + integ_acc - kd * dmeas, lo, hi);
				// Arithmetic shift floors toward minus infinity.
				drive_hold = data_t'(total >>> GAIN_FRAC_BITS);
				prev_meas  = meas;
			end
		end
		whole = integ_acc >>> GAIN_FRAC_BITS;
		if (whole > smax)
			whole = smax;
		if (whole < -smax - 1)
			whole = -smax - 1;
		outcome.drive          = drive_hold;
		outcome.integral_whole = data_t'(whole);
		pending_outcomes.push_back(outcome);
	endtask

	task automatic flag_error(string msg);
		$display("ERROR %0t: %s", $time, msg);
		mismatches++;
	endtask

	// -----------------------------------------------------------------------
	// Configuration port
	// -----------------------------------------------------------------------
	task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		// Mirror the write; the block is idle so nothing in flight sees it.
		case (idx)
			CFG_PROP_GAIN:    kp_cfg      = gain_t'(value);
			CFG_INTEG_GAIN:   ki_cfg      = gain_t'(value);
			CFG_DERIV_GAIN:   kd_cfg      = gain_t'(value);
			CFG_OUT_MIN:      min_cfg     = data_t'(value);
			CFG_OUT_MAX:      max_cfg     = data_t'(value);
			CFG_REVERSE:      reverse_cfg = value[0];
			CFG_PROP_ON_MEAS: pom_cfg     = value[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Program every register; flag registers get random upper bits.
	task automatic program_loop(gain_t kp, gain_t ki, gain_t kd, data_t mn, data_t mx,
			logic rev, logic pom);
		logic [CFG_DATA_WIDTH-1:0] noise;
		noise = CFG_DATA_WIDTH'($urandom);
		write_reg(CFG_PROP_GAIN, kp);
		write_reg(CFG_INTEG_GAIN, ki);
		write_reg(CFG_DERIV_GAIN, kd);
		write_reg(CFG_OUT_MIN, mn);
		write_reg(CFG_OUT_MAX, mx);
		write_reg(CFG_REVERSE, {noise[CFG_DATA_WIDTH-1:1], rev});
		write_reg(CFG_PROP_ON_MEAS, {noise[CFG_DATA_WIDTH-2:0], pom});
	endtask

	// -----------------------------------------------------------------------
	// Sample channel
	// -----------------------------------------------------------------------
	task automatic send_sample(op_t op, data_t meas, data_t sp, logic auto_on);
		int gap;
		gap = stream_fast ? 0 : $urandom_range(0, 8);
		@(negedge clk);
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		// With no gap valid just stays high and only the payload moves.
		sample_ch.valid       <= 1'b1;
		sample_ch.operation   <= op;
		sample_ch.measurement <= meas;
		sample_ch.setpoint    <= sp;
		sample_ch.auto_enable <= auto_on;
		do @(posedge clk); while (!sample_ch.ready);
		regulate(op, meas, sp, auto_on);
	endtask

	// Drop valid and wait until every queued result has come back.
	task automatic drain();
		@(negedge clk);
		sample_ch.valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// -----------------------------------------------------------------------
	// Result channel: stall at random, check every transfer in order.
	// -----------------------------------------------------------------------
	initial begin : result_sink
		int       stall;
		outcome_t want;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_off_cycles > 0) begin
				stall           = hold_off_cycles;
				hold_off_cycles = 0;
			end else begin
				stall = stream_fast ? 0 : $urandom_range(0, 8);
			end
			@(negedge clk);
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			results_seen++;
			if (pending_outcomes.size() == 0) begin
				flag_error($sformatf("result %0d with no sample pending", results_seen));
			end else begin
				want = pending_outcomes.pop_front();
				if (result_ch.drive !== want.drive)
					flag_error($sformatf("result %0d drive %0d, expected %0d",
						results_seen, result_ch.drive, want.drive));
				if (result_ch.integral_whole !== want.integral_whole)
					flag_error($sformatf("result %0d integral %0d, expected %0d",
						results_seen, result_ch.integral_whole, want.integral_whole));
			end
		end
	end

	// End the run if neither channel moves for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("ERROR %0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("simulation failed");
		$finish;
	end

	// -----------------------------------------------------------------------
	// Tests
	// -----------------------------------------------------------------------

	// Registers at reset values: zero gains keep drive and integral at zero.
	task automatic test_reset_state();
		send_sample(OP_COMPUTE, data_t'(32767), data_t'(-32768), 1'b1);
		send_sample(OP_COMPUTE, data_t'(-32768), data_t'(32767), 1'b0);
		send_sample(OP_COMPUTE, data_t'(100), data_t'(-100), 1'b1);
		drain();
	endtask

	task automatic test_directed();
		// Plain loop: Kp 1.0, Ki 0.25, Kd 0.5, limits +-1000.
		program_loop(16'h0100, 16'h0040, 16'h0080, data_t'(-1000), data_t'(1000), 1'b0, 1'b0);
		send_sample(OP_COMPUTE, data_t'(0), data_t'(100), 1'b1);
		send_sample(OP_COMPUTE, data_t'(10), data_t'(100), 1'b1);
		send_sample(OP_COMPUTE, data_t'(-32768), data_t'(32767), 1'b1);
		send_sample(OP_COMPUTE, data_t'(32767), data_t'(-32768), 1'b1);
		// Manual mode holds the drive whatever comes in.
		send_sample(OP_COMPUTE, data_t'(5), data_t'(5), 1'b0);
		send_sample(OP_COMPUTE, data_t'(-32768), data_t'(32767), 1'b0);
		// Back to auto: integral restarts from the held drive.
		send_sample(OP_COMPUTE, data_t'(0), data_t'(0), 1'b1);
		send_sample(OP_CLEAR, data_t'($urandom), data_t'($urandom), 1'b1);
		send_sample(OP_COMPUTE, data_t'(20), data_t'(0), 1'b1);
		drain();

		// Reverse action, proportional on measurement, full-scale gains and limits.
		program_loop(16'hFFFF, 16'hFFFF, 16'hFFFF, data_t'(-32768), data_t'(32767), 1'b1, 1'b1);
		send_sample(OP_COMPUTE, data_t'(100), data_t'(0), 1'b1);
		send_sample(OP_COMPUTE, data_t'(-100), data_t'(0), 1'b1);
		send_sample(OP_COMPUTE, data_t'(32767), data_t'(32767), 1'b1);
		send_sample(OP_COMPUTE, data_t'(-32768), data_t'(-32768), 1'b1);
		// Clear with auto low must not count as a mode change.
		send_sample(OP_CLEAR, data_t'(-1), data_t'(-1), 1'b0);
		send_sample(OP_COMPUTE, data_t'(0), data_t'(0), 1'b0);
		send_sample(OP_COMPUTE, data_t'(1), data_t'(-1), 1'b1);
		drain();

		// Crossed limits: the upper limit test decides first.
		program_loop(16'h0080, 16'h0020, 16'h0010, data_t'(500), data_t'(-500), 1'b0, 1'b0);
		send_sample(OP_COMPUTE, data_t'(0), data_t'(0), 1'b1);
		send_sample(OP_COMPUTE, data_t'(300), data_t'(-300), 1'b0);
		send_sample(OP_COMPUTE, data_t'(-300), data_t'(300), 1'b1);
		drain();

		// Equal limits, then a write outside the map that must change nothing.
		program_loop(16'h0100, 16'h0100, 16'h0000, data_t'(7), data_t'(7), 1'b0, 1'b1);
		write_reg(NO_SUCH_REG, CFG_DATA_WIDTH'($urandom));
		send_sample(OP_COMPUTE, data_t'(1234), data_t'(-1234), 1'b1);
		send_sample(OP_COMPUTE, data_t'(0), data_t'(0), 1'b1);
		drain();
	endtask

	function automatic gain_t pick_gain();
		case ($urandom_range(0, 9))
			0:       return gain_t'(0);
			1:       return gain_t'('1);
			2, 3, 4,
			5, 6:    return gain_t'($urandom_range(0, 1023));
			default: return gain_t'($urandom);
		endcase
	endfunction

	// One sample of a tracking sequence: the measurement mostly takes small steps,
	// sometimes lands near the setpoint, with manual stretches, clears and full-range jumps.
	task automatic random_sample();
		op_t   op;
		data_t sp;
		logic  auto_on;
		int    pick;
		if (manual_left > 0) begin
			auto_on = 1'b0;
			manual_left--;
		end else if ($urandom_range(0, 99) < 5) begin
			auto_on     = 1'b0;
			manual_left = $urandom_range(0, 4);
		end else begin
			auto_on = 1'b1;
		end
		if ($urandom_range(0, 49) == 0)
			walk_sp = data_t'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 60)
			walk_meas = data_t'(int'(walk_meas) + int'($urandom_range(0, 64)) - 32);
		else if (pick < 85)
			walk_meas = data_t'($urandom);
		else
			walk_meas = data_t'(int'(walk_sp) + int'($urandom_range(0, 8)) - 4);
		sp = ($urandom_range(0, 19) == 0) ? data_t'($urandom) : walk_sp;
		op = ($urandom_range(0, 99) < 3) ? OP_CLEAR : OP_COMPUTE;
		send_sample(op, walk_meas, sp, auto_on);
	endtask

	task automatic test_random_phases();
		data_t mn, mx, t;
		int    choice;
		for (int phase = 0; phase < PHASES; phase++) begin
			// Force full-range limits once and crossed limits once.
			choice = (phase < 2) ? phase : $urandom_range(0, 9);
			case (choice)
				0: begin
					mn = data_t'(-32768);
					mx = data_t'(32767);
				end
				1: begin
					mn = data_t'($urandom);
					mx = data_t'($urandom);
					if (mn < mx) begin
						t  = mn;
						mn = mx;
						mx = t;
					end
				end
				default: begin
					mn = data_t'(-int'($urandom_range(0, 3000)));
					mx = data_t'($urandom_range(1, 3000));
				end
			endcase
			program_loop(pick_gain(), pick_gain(), pick_gain(), mn, mx,
				1'($urandom), 1'($urandom));
			// One phase runs with no idling on either side.
			stream_fast = (phase == 5);
			for (int n = 0; n < PHASE_ITEMS; n++)
				random_sample();
			drain();
		end
		stream_fast = 1'b0;
	endtask

	// Stall the result side for a long stretch while samples keep coming,
	// so the pipeline fills and the sample channel backs up.
	task automatic test_backpressure();
		program_loop(16'h0100, 16'h0010, 16'h0040, data_t'(-2000), data_t'(2000), 1'b0, 1'b0);
		hold_off_cycles = HOLD_OFF_LEN;
		stream_fast     = 1'b1;
		for (int n = 0; n < PRESSURE_ITEMS; n++)
			random_sample();
		stream_fast = 1'b0;
		drain();
	endtask

	initial begin
		// Hold every input at a known value through reset.
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_index             = CFG_PROP_GAIN;
		cfg_data              = '0;
		sample_ch.valid       = 1'b0;
		sample_ch.operation   = OP_COMPUTE;
		sample_ch.measurement = '0;
		sample_ch.setpoint    = '0;
		sample_ch.auto_enable = 1'b0;
		result_ch.ready       = 1'b0;

		// Predictor starts from the reset state of the block.
		kp_cfg          = '0;
		ki_cfg          = '0;
		kd_cfg          = '0;
		min_cfg         = '0;
		max_cfg         = OUT_MAX_RESET;
		reverse_cfg     = 1'b0;
		pom_cfg         = 1'b0;
		integ_acc       = 0;
		prev_meas       = '0;
		drive_hold      = '0;
		auto_prev       = 1'b1;
		mismatches      = 0;
		results_seen    = 0;
		stream_fast     = 1'b0;
		hold_off_cycles = 0;
		manual_left     = 0;
		walk_meas       = '0;
		walk_sp         = '0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_directed();
		test_random_phases();
		test_backpressure();

		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### sim.f
+incdir+design
design/pidr_pkg.sv
design/pidr_sample_if.sv
design/pidr_result_if.sv
design/pid_regulator.sv
bench/pid_regulator_tb.sv
